@@ design/lds_pkg.sv @@
package lds_pkg;

  localparam int OFF_W = 40;
  localparam int CAP_W = 40;
  localparam int CMP_W = ((OFF_W > CAP_W) ? OFF_W : CAP_W) + 2;
  localparam int HDR_BYTES = 32;
  localparam int HDR_TAIL = HDR_BYTES - 20;
  localparam int CFG_IDX_W = 32;
  localparam logic [31:0] CRC_POLY = 32'h82f6_3b78;

  typedef enum logic [2:0] {
    CFG_CAPACITY  = 3'd0,
    CFG_MAGIC     = 3'd1,
    CFG_KIND_LO   = 3'd2,
    CFG_KIND_HI   = 3'd3,
    CFG_ACTIVITY  = 3'd4,
    CFG_RECEIPT   = 3'd5
  } cfg_reg_t;

  typedef enum logic [0:0] {
    PH_HEADER = 1'b0,
    PH_BODY   = 1'b1
  } scan_phase_t;

  typedef struct packed {
    logic [CAP_W-1:0] capacity;
    logic [31:0]      magic;
    logic [7:0]       kind_lo;
    logic [7:0]       kind_hi;
    logic [7:0]       activity;
    logic [7:0]       receipt;
  } cfg_t;

  typedef struct packed {
    scan_phase_t      phase;
    logic             finished;
    logic [OFF_W-1:0] offset;
    logic [4:0]       fidx;
    logic [63:0]      shift;
    logic [7:0]       kind;
    logic             resnz;
    logic [63:0]      seq;
    logic [31:0]      body_rem;
    logic [31:0]      hcrc;
    logic [31:0]      crc;
    logic [63:0]      pend;
    logic             have_act;
    logic [63:0]      durable;
  } scan_state_t;

  localparam scan_state_t SCAN_CLEAR = '{
    phase:    PH_HEADER,
    finished: 1'b0,
    offset:   '0,
    fidx:     '0,
    shift:    '0,
    kind:     '0,
    resnz:    1'b0,
    seq:      '0,
    body_rem: '0,
    hcrc:     '0,
    crc:      '1,
    pend:     '0,
    have_act: 1'b0,
    durable:  '1
  };

endpackage

@@ design/log_durable_head_scanner.sv @@
// Log segment scanner with durable-sequence tracking.
// Segment bytes enter on the input channel (in_valid/in_ready, data_byte,
// restart), one byte per item, in file order; restart marks offset zero of a
// new scan. When a scan ends, one item leaves on the output channel
// (out_valid/out_ready) with scan_status and durable_sequence.
// Registers are written through cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. The user must write them only while
// the block is idle; the block does not enforce this. A byte is taken into
// an input register, processed by the byte-wide CRC-32C and header field
// logic, and its result, if any, is held in an output register. One byte
// per cycle is sustained, set by the single state update per byte, while
// no scan-ending byte waits on a stalled receiver.
// Reset loads the register defaults and clears all scan state.
// While a result waits on a stalled receiver, bytes that end no scan still
// pass through; a byte that would end a scan waits in the input register,
// and in_ready drops until the result is taken.
module log_durable_head_scanner
  import lds_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  input  logic                 restart,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 scan_status,
  output logic [63:0]          durable_sequence,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CAP_W-1:0]     cfg_data
);

  cfg_t        cfg;
  logic        in_vq;
  logic [7:0]  byte_q;
  logic        restart_q;
  logic        go;
  logic        res;
  logic        res_status;
  logic [63:0] res_sequence;

  lds_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lds_scan_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .go           (go),
    .byte_in      (byte_q),
    .restart_in   (restart_q),
    .res          (res),
    .res_status   (res_status),
    .res_sequence (res_sequence)
  );

  assign go = in_vq && (!res || !out_valid || out_ready);
  assign in_ready = !in_vq || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vq <= 1'b0;
    end else if (in_ready) begin
      in_vq <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= data_byte;
      restart_q <= restart;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && res) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res) begin
      scan_status <= res_status;
      durable_sequence <= res_sequence;
    end
  end

  a_corrupt_no_sequence: assert property (@(posedge clk) disable iff (rst)
    out_valid && scan_status |-> durable_sequence == '1)
    else $error("corrupt result carries a durable sequence");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    go && res |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_in_held_when_stalled: assert property (@(posedge clk) disable iff (rst)
    in_vq && !go |=> in_vq && $stable(byte_q) && $stable(restart_q))
    else $error("stalled input item lost");

endmodule

@@ design/lds_cfg_regs.sv @@
module lds_cfg_regs
  import lds_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CAP_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  logic wr_en;

  assign cfg_ready = 1'b1;
  assign wr_en = cfg_valid && (cfg_index[CFG_IDX_W-1:3] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity <= CAP_W'(1048576);
      cfg.magic    <= '0;
      cfg.kind_lo  <= 8'd1;
      cfg.kind_hi  <= 8'd4;
      cfg.activity <= 8'd1;
      cfg.receipt  <= 8'd2;
    end else if (wr_en) begin
      case (cfg_reg_t'(cfg_index[2:0]))
        CFG_CAPACITY: cfg.capacity <= cfg_data;
        CFG_MAGIC:    cfg.magic    <= cfg_data[31:0];
        CFG_KIND_LO:  cfg.kind_lo  <= cfg_data[7:0];
        CFG_KIND_HI:  cfg.kind_hi  <= cfg_data[7:0];
        CFG_ACTIVITY: cfg.activity <= cfg_data[7:0];
        CFG_RECEIPT:  cfg.receipt  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ design/lds_scan_core.sv @@
module lds_scan_core
  import lds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        go,
  input  logic [7:0]  byte_in,
  input  logic        restart_in,
  output logic        res,
  output logic        res_status,
  output logic [63:0] res_sequence
);

  localparam logic [4:0] IDX_FIRST     = 5'd0;
  localparam logic [4:0] IDX_MAGIC_END = 5'd3;
  localparam logic [4:0] IDX_KIND      = 5'd4;
  localparam logic [4:0] IDX_RSV_FIRST = 5'd5;
  localparam logic [4:0] IDX_RSV_MID   = 5'd6;
  localparam logic [4:0] IDX_RSV_LAST  = 5'd7;
  localparam logic [4:0] IDX_SEQ_END   = 5'd15;
  localparam logic [4:0] IDX_LEN_END   = 5'd19;
  localparam logic [4:0] IDX_CRC_END   = 5'd23;
  localparam logic [4:0] IDX_HDR_END   = 5'd31;

  scan_state_t st;
  scan_state_t cur;
  scan_state_t nx;
  logic        fin;
  logic        fin_bad;
  logic        rec_done;
  logic [63:0] sh;
  logic        resnz_n;
  logic [31:0] crc_n;
  logic [31:0] rem_n;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
    end
    return r;
  endfunction

  function automatic logic no_room(input logic [OFF_W-1:0] off, input logic [CAP_W-1:0] cap);
    return (CMP_W'(off) + CMP_W'(HDR_BYTES)) > CMP_W'(cap);
  endfunction

  assign cur = restart_in ? SCAN_CLEAR : st;
  assign sh = {cur.shift[55:0], byte_in};
  assign crc_n = crc_byte(cur.crc, byte_in);
  assign rem_n = cur.body_rem - {31'd0, (cur.body_rem != 32'd0)};
  assign resnz_n = cur.resnz | (byte_in != 8'd0);

  always_comb begin
    nx = cur;
    fin = 1'b0;
    fin_bad = 1'b0;
    rec_done = 1'b0;
    if (!cur.finished) begin
      if (cur.phase == PH_HEADER) begin
        if ((cur.fidx == IDX_FIRST) && no_room(cur.offset, cfg.capacity)) begin
          fin = 1'b1;
        end else begin
          nx.shift = sh;
          nx.offset = cur.offset + OFF_W'(1);
          nx.fidx = cur.fidx + 5'd1;
          case (cur.fidx)
            IDX_MAGIC_END: begin
              if (sh[31:0] == 32'd0) begin
                fin = 1'b1;
              end else if (sh[31:0] != cfg.magic) begin
                fin = 1'b1;
                fin_bad = 1'b1;
              end
            end
            IDX_KIND: begin
              nx.kind = byte_in;
              if ((byte_in < cfg.kind_lo) || (byte_in > cfg.kind_hi)) begin
                fin = 1'b1;
                fin_bad = 1'b1;
              end
            end
            IDX_RSV_FIRST, IDX_RSV_MID: begin
              nx.resnz = resnz_n;
            end
            IDX_RSV_LAST: begin
              nx.resnz = resnz_n;
              if (resnz_n) begin
                fin = 1'b1;
                fin_bad = 1'b1;
              end
            end
            IDX_SEQ_END: begin
              nx.seq = sh;
            end
            IDX_LEN_END: begin
              nx.body_rem = sh[31:0];
              if ((CMP_W'(nx.offset) + CMP_W'(HDR_TAIL) + CMP_W'(sh[31:0]))
                  > CMP_W'(cfg.capacity)) begin
                fin = 1'b1;
                fin_bad = 1'b1;
              end
            end
            IDX_CRC_END: begin
              nx.hcrc = sh[31:0];
            end
            IDX_HDR_END: begin
              nx.fidx = IDX_FIRST;
              nx.resnz = 1'b0;
              if (cur.body_rem == 32'd0) begin
                if (cur.hcrc != 32'd0) begin
                  fin = 1'b1;
                  fin_bad = 1'b1;
                end else begin
                  rec_done = 1'b1;
                end
              end else begin
                nx.phase = PH_BODY;
                nx.crc = '1;
              end
            end
            default: begin
            end
          endcase
        end
      end else begin
        nx.crc = crc_n;
        nx.offset = cur.offset + OFF_W'(1);
        nx.body_rem = rem_n;
        if (rem_n == 32'd0) begin
          if (~crc_n != cur.hcrc) begin
            fin = 1'b1;
            fin_bad = 1'b1;
          end else begin
            rec_done = 1'b1;
          end
        end
      end
    end
    if (rec_done) begin
      if (cur.kind == cfg.activity) begin
        nx.pend = cur.seq;
        nx.have_act = 1'b1;
      end else if ((cur.kind == cfg.receipt) && cur.have_act && (cur.seq == cur.pend)) begin
        nx.durable = cur.pend;
        nx.have_act = 1'b0;
      end
      nx.phase = PH_HEADER;
      nx.fidx = IDX_FIRST;
      if (no_room(nx.offset, cfg.capacity)) begin
        fin = 1'b1;
      end
    end
    if (fin) begin
      nx.finished = 1'b1;
    end
  end

  assign res = fin;
  assign res_status = fin_bad;
  assign res_sequence = fin_bad ? '1 : nx.durable;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= SCAN_CLEAR;
    end else if (go) begin
      st <= nx;
    end
  end

  a_one_result_per_scan: assert property (@(posedge clk) disable iff (rst)
    go && res |-> (!st.finished || restart_in))
    else $error("result produced after the scan had already ended");

  a_body_at_field_zero: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_BODY |-> st.fidx == IDX_FIRST)
    else $error("header field index not cleared in body phase");

  a_body_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_BODY) && !st.finished |-> st.body_rem != 32'd0)
    else $error("body phase with no body bytes left");

endmodule
